>>> rtl/core/bmp_pkg.sv
// Shared constants and types for the binomial coefficient modulo prime block.
// Holds the modulus, the Barrett reduction constant, stream widths and the
// table fill state type. No dependencies.
package bmp_pkg;

    // Modulus and Fermat exponent for inverses
    localparam int          COEF_W    = 30;
    localparam logic [29:0] MOD_P     = 30'd1000000007;
    localparam logic [29:0] FERMAT_EXP = MOD_P - 30'd2;
    localparam int          EXP_BITS  = 30;
    localparam int          EXP_IW    = $clog2(EXP_BITS);

    // Multiples of p at remainder width
    localparam logic [31:0] MOD_P_X1  = 32'(64'(MOD_P));
    localparam logic [31:0] MOD_P_X2  = 32'(64'(MOD_P) * 64'd2);
    localparam logic [31:0] MOD_P_X3  = 32'(64'(MOD_P) * 64'd3);

    // Barrett constant floor(2^60 / p), 31 bits
    localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'(MOD_P));

    // Modular multiplier latency in cycles
    localparam int          MM_LAT    = 4;

    // Stream widths
    localparam int          COUNT_W     = 12;
    localparam int          IN_TDATA_W  = 24;
    localparam int          OUT_TDATA_W = 32;

    // Result queue
    localparam int          FIFO_DEPTH = 16;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW    = FIFO_AW + 1;

    localparam int          MAX_N_DEFAULT = 2048;

    // Table fill sequencer
    typedef enum logic [3:0] {
        ST_ZERO,
        ST_FACT_ISSUE,
        ST_FACT_WAIT,
        ST_EXP_MUL_ISSUE,
        ST_EXP_MUL_WAIT,
        ST_EXP_SQR_ISSUE,
        ST_EXP_SQR_WAIT,
        ST_INV_ISSUE,
        ST_INV_WAIT,
        ST_DONE
    } t_init_state;

endpackage

>>> rtl/core/binomial_mod_prime.sv
// Top level of the binomial coefficient modulo prime block.
// Holds the factorial tables, their fill sequencer, the query pipeline and the
// result queue. Depends on bmp_pkg and bmp_modmul.
//
// Answers C(n,k) mod 1000000007 from a table of i! and a table of 1/i! for
// i = 0..MAX_N. After reset the block fills both tables and holds s_tready low
// until done: i! is built upward with one modular multiply per entry,
// 1/MAX_N! comes from a square-and-multiply power with exponent p-2, and the
// inverses are then built downward as 1/(i-1)! = i * 1/i!. Each step waits on
// the shared four-stage modular multiplier. Afterward a query is taken every
// cycle while fewer than 16 queries are in flight; a result reaches the output
// queue through one register stage, one table read and two pipelined modular
// multiplies. A 16-entry result queue with credit counting lets queries keep
// flowing while results wait to be taken. A query with k > n or n > MAX_N
// returns coefficient 0 with out_of_range set.
module binomial_mod_prime import bmp_pkg::*; #(
    parameter int MAX_N = MAX_N_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Query stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [11:0] top_count, [23:12] choose_count
    // Result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [29:0] coefficient, [31:30] zero
    output logic [0:0]             o_m_tuser    // [0] out_of_range
);

    localparam int AW     = $clog2(MAX_N + 1);
    localparam int DLY_W  = 2 * MM_LAT;

    // ---------------------------------------------------------------
    // Declarations
    // ---------------------------------------------------------------
    t_init_state       r_state, n_state;
    logic [AW-1:0]     r_idx;
    logic [COEF_W-1:0] r_acc;
    logic [COEF_W-1:0] r_sq;
    logic [COEF_W-1:0] r_pow;
    logic [EXP_IW-1:0] r_bit;

    logic              w_exp_bit;
    logic              w_idx_last;
    logic              w_idx_one;

    logic              w_mma_valid;
    logic [COEF_W-1:0] w_mma_a, w_mma_b;
    logic              w_mma_ovalid;
    logic [COEF_W-1:0] w_mma_res;
    logic              w_mmb_valid;
    logic              w_mmb_ovalid;
    logic [COEF_W-1:0] w_mmb_res;

    logic              w_fact_we;
    logic [AW-1:0]     w_fact_waddr;
    logic [COEF_W-1:0] w_fact_wdata;
    logic              w_inv_we;
    logic [AW-1:0]     w_inv_waddr;
    logic [COEF_W-1:0] w_inv_wdata;

    logic [COEF_W-1:0] r_fact_mem [0:MAX_N];
    logic [COEF_W-1:0] r_inv_mem  [0:MAX_N];

    logic              w_acc;
    logic [COUNT_W-1:0] w_n, w_k, w_nk;
    logic              w_oor;

    logic              r_a_valid;
    logic              r_a_oor;
    logic [AW-1:0]     r_a_addr_n, r_a_addr_k, r_a_addr_nk;

    logic              r_b_valid;
    logic              r_b_oor;
    logic [COEF_W-1:0] r_b_fact, r_b_invk, r_b_invnk;

    logic [COEF_W-1:0] r_invk_dly [0:MM_LAT-1];
    logic [DLY_W-1:0]  r_oor_dly;

    logic [COEF_W-1:0] r_fifo_coef [0:FIFO_DEPTH-1];
    logic              r_fifo_oor  [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_fifo_cnt, r_credit;
    logic              w_push, w_pop;
    logic              w_push_oor;
    logic [COEF_W-1:0] w_push_coef;

    // ---------------------------------------------------------------
    // Table fill sequencer
    // ---------------------------------------------------------------
    assign w_exp_bit  = FERMAT_EXP[r_bit];
    assign w_idx_last = (r_idx == AW'(MAX_N));
    assign w_idx_one  = (r_idx == AW'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ZERO:          n_state = ST_FACT_ISSUE;
            ST_FACT_ISSUE:    n_state = ST_FACT_WAIT;
            ST_FACT_WAIT: begin
                if (w_mma_ovalid) begin
                    n_state = w_idx_last ? ST_EXP_MUL_ISSUE : ST_FACT_ISSUE;
                end
            end
            ST_EXP_MUL_ISSUE: n_state = w_exp_bit ? ST_EXP_MUL_WAIT : ST_EXP_SQR_ISSUE;
            ST_EXP_MUL_WAIT: begin
                if (w_mma_ovalid) begin
                    n_state = ST_EXP_SQR_ISSUE;
                end
            end
            ST_EXP_SQR_ISSUE: n_state = ST_EXP_SQR_WAIT;
            ST_EXP_SQR_WAIT: begin
                if (w_mma_ovalid) begin
                    n_state = (r_bit == EXP_IW'(EXP_BITS - 1)) ? ST_INV_ISSUE
                                                               : ST_EXP_MUL_ISSUE;
                end
            end
            ST_INV_ISSUE:     n_state = ST_INV_WAIT;
            ST_INV_WAIT: begin
                if (w_mma_ovalid) begin
                    n_state = w_idx_one ? ST_DONE : ST_INV_ISSUE;
                end
            end
            ST_DONE:          n_state = ST_DONE;
            default:          n_state = ST_ZERO;
        endcase
    end

    // Sequencer outputs: multiplier operands and table writes
    always_comb begin
        w_mma_valid  = 1'b0;
        w_mma_a      = r_b_fact;
        w_mma_b      = r_b_invnk;
        w_fact_we    = 1'b0;
        w_fact_waddr = r_idx;
        w_fact_wdata = w_mma_res;
        w_inv_we     = 1'b0;
        w_inv_waddr  = r_idx;
        w_inv_wdata  = r_pow;
        case (r_state)
            ST_ZERO: begin
                w_fact_we    = 1'b1;
                w_fact_waddr = '0;
                w_fact_wdata = COEF_W'(1);
            end
            ST_FACT_ISSUE: begin
                w_mma_valid = 1'b1;
                w_mma_a     = r_acc;
                w_mma_b     = COEF_W'(r_idx);
            end
            ST_FACT_WAIT: begin
                w_fact_we = w_mma_ovalid;
            end
            ST_EXP_MUL_ISSUE: begin
                w_mma_valid = w_exp_bit;
                w_mma_a     = r_pow;
                w_mma_b     = r_sq;
            end
            ST_EXP_SQR_ISSUE: begin
                w_mma_valid = 1'b1;
                w_mma_a     = r_sq;
                w_mma_b     = r_sq;
            end
            ST_INV_ISSUE: begin
                w_mma_valid = 1'b1;
                w_mma_a     = r_pow;
                w_mma_b     = COEF_W'(r_idx);
                w_inv_we    = 1'b1;
            end
            ST_INV_WAIT: begin
                w_inv_we    = w_mma_ovalid & w_idx_one;
                w_inv_waddr = '0;
                w_inv_wdata = w_mma_res;
            end
            ST_DONE: begin
                w_mma_valid = r_b_valid;
            end
            default: begin
                w_mma_valid = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ZERO;
            r_idx   <= AW'(1);
            r_acc   <= COEF_W'(1);
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_FACT_WAIT: begin
                    if (w_mma_ovalid) begin
                        r_acc <= w_mma_res;
                        if (w_idx_last) begin
                            r_sq  <= w_mma_res;
                            r_pow <= COEF_W'(1);
                            r_bit <= '0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                ST_EXP_MUL_WAIT: begin
                    if (w_mma_ovalid) begin
                        r_pow <= w_mma_res;
                    end
                end
                ST_EXP_SQR_WAIT: begin
                    if (w_mma_ovalid) begin
                        r_sq  <= w_mma_res;
                        r_bit <= r_bit + EXP_IW'(1);
                    end
                end
                ST_INV_WAIT: begin
                    if (w_mma_ovalid) begin
                        r_pow <= w_mma_res;
                        r_idx <= r_idx - AW'(1);
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Tables: one write port, registered reads
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_fact_we) begin
            r_fact_mem[w_fact_waddr] <= w_fact_wdata;
        end
        r_b_fact <= r_fact_mem[r_a_addr_n];
    end

    always_ff @(posedge i_clk) begin
        if (w_inv_we) begin
            r_inv_mem[w_inv_waddr] <= w_inv_wdata;
        end
        r_b_invk  <= r_inv_mem[r_a_addr_k];
        r_b_invnk <= r_inv_mem[r_a_addr_nk];
    end

    // ---------------------------------------------------------------
    // Query front: transfer, range check, table addresses
    // ---------------------------------------------------------------
    assign o_s_tready = (r_state == ST_DONE) && (r_credit < FIFO_CW'(FIFO_DEPTH));
    assign w_acc      = i_s_tvalid & o_s_tready;

    assign w_n   = i_s_tdata[COUNT_W-1:0];
    assign w_k   = i_s_tdata[2*COUNT_W-1:COUNT_W];
    assign w_nk  = w_n - w_k;
    assign w_oor = (32'(w_n) > 32'(MAX_N)) || (w_k > w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_acc;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_oor     <= w_oor;
        r_a_addr_n  <= w_oor ? '0 : AW'(w_n);
        r_a_addr_k  <= w_oor ? '0 : AW'(w_k);
        r_a_addr_nk <= w_oor ? '0 : AW'(w_nk);
        r_b_oor     <= r_a_oor;
    end

    // ---------------------------------------------------------------
    // Two modular multiplies: n! / (n-k)!, then / k!
    // ---------------------------------------------------------------
    bmp_modmul u_mm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mma_valid),
        .i_a     (w_mma_a),
        .i_b     (w_mma_b),
        .o_valid (w_mma_ovalid),
        .o_res   (w_mma_res)
    );

    assign w_mmb_valid = w_mma_ovalid & (r_state == ST_DONE);

    bmp_modmul u_mm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mmb_valid),
        .i_a     (w_mma_res),
        .i_b     (r_invk_dly[MM_LAT-1]),
        .o_valid (w_mmb_ovalid),
        .o_res   (w_mmb_res)
    );

    // Side data delayed to meet the multiplier outputs
    always_ff @(posedge i_clk) begin
        r_invk_dly[0] <= r_b_invk;
        for (int i = 1; i < MM_LAT; i++) begin
            r_invk_dly[i] <= r_invk_dly[i-1];
        end
        r_oor_dly <= {r_oor_dly[DLY_W-2:0], r_b_oor};
    end

    // ---------------------------------------------------------------
    // Result queue with credit count of queries in flight
    // ---------------------------------------------------------------
    assign w_push      = w_mmb_ovalid;
    assign w_push_oor  = r_oor_dly[DLY_W-1];
    assign w_push_coef = w_push_oor ? '0 : w_mmb_res;
    assign w_pop       = o_m_tvalid & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo_coef[r_wr_ptr] <= w_push_coef;
            r_fifo_oor[r_wr_ptr]  <= w_push_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
            r_credit   <= r_credit + FIFO_CW'(w_acc) - FIFO_CW'(w_pop);
        end
    end

    assign o_m_tvalid   = (r_fifo_cnt != '0);
    assign o_m_tdata    = {{(OUT_TDATA_W - COEF_W){1'b0}}, r_fifo_coef[r_rd_ptr]};
    assign o_m_tuser[0] = r_fifo_oor[r_rd_ptr];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_query_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_state == ST_DONE)
        else $error("query reached the tables before the fill finished");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= FIFO_CW'(FIFO_DEPTH))
        else $error("more queries in flight than queue entries");

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_credit)
        else $error("queue holds more results than queries in flight");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tdata == '0)
        else $error("out-of-range result carries a nonzero coefficient");

endmodule

>>> rtl/core/bmp_modmul.sv
// Pipelined modular multiplier: a * b mod p with Barrett reduction.
// Four register stages, one operation per cycle. Depends on bmp_pkg.
module bmp_modmul import bmp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [COEF_W-1:0] i_a,
    input  logic [COEF_W-1:0] i_b,
    output logic              o_valid,
    output logic [COEF_W-1:0] o_res
);

    logic [MM_LAT-1:0] r_v;
    logic [59:0]       r_prod;
    logic [61:0]       r_qh;
    logic [31:0]       r_lo;
    logic [31:0]       r_rem;
    logic [COEF_W-1:0] r_res;

    logic [59:0]       w_prod;
    logic [61:0]       w_qh;
    logic [31:0]       w_qp;
    logic [31:0]       w_rem;
    logic [31:0]       w_fix;

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MM_LAT-2:0], i_valid};
        end
    end

    // Stage 1: full product, below p^2 < 2^60
    assign w_prod = 60'(i_a) * 60'(i_b);

    // Stage 2: quotient estimate (x >> 29) * m
    assign w_qh = 62'(r_prod[59:29]) * 62'(BARRETT_M);

    // Stage 3: remainder estimate in [0, 3p) on 32 bits
    assign w_qp  = 32'(r_qh[61:31]) * MOD_P_X1;
    assign w_rem = r_lo - w_qp;

    // Stage 4: at most two corrections
    always_comb begin
        if (r_rem >= MOD_P_X2) begin
            w_fix = r_rem - MOD_P_X2;
        end else if (r_rem >= MOD_P_X1) begin
            w_fix = r_rem - MOD_P_X1;
        end else begin
            w_fix = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_qh   <= w_qh;
        r_lo   <= r_prod[31:0];
        r_rem  <= w_rem;
        r_res  <= COEF_W'(w_fix);
    end

    assign o_valid = r_v[MM_LAT-1];
    assign o_res   = r_res;

    // Barrett estimate is never off by more than two multiples of p
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> r_rem < MOD_P_X3)
        else $error("modmul remainder estimate out of range");

    // Reduced result is a residue
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res < MOD_P)
        else $error("modmul result not reduced");

    // Every result traces back to an issued operation
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, MM_LAT))
        else $error("modmul result without issue");

endmodule

>>> bench/testbench.sv
// Self-checking bench for binomial_mod_prime: drives (n, k) queries, predicts
// C(n,k) mod p from its own factorial tables and checks every result transfer.
// Depends on bmp_pkg and the binomial_mod_prime RTL.
module testbench;
    import bmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   TABLE_TOP = MAX_N_DEFAULT;
    localparam longint unsigned      PRIME     = 64'd1000000007;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

    // Expected content of one result transfer
    typedef struct {
        logic [COEF_W-1:0] coefficient;
        logic              out_of_range;
    } t_binom_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [11:0] top_count, [23:12] choose_count
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [29:0] coefficient, [31:30] zero
    logic [0:0]             o_m_tuser;   // [0] out_of_range

    longint unsigned fact_mod     [0:TABLE_TOP];
    longint unsigned inv_fact_mod [0:TABLE_TOP];
    t_binom_result   pending_results[$];

    int unsigned mismatch_count = 0;
    bit          idle_on        = 1'b0;
    int          hold_req       = 0;
    int          hold_left      = 0;
    int          stall_left     = 0;

    binomial_mod_prime dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: table fill plus a slow stalled run, with wide margin
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
        return ((a % PRIME) * (b % PRIME)) % PRIME;
    endfunction

    // Modular power by square-and-multiply
    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex);
        longint unsigned acc = 1;
        longint unsigned sq  = base % PRIME;
        while (ex != 0) begin
            if (ex[0])
                acc = mul_mod(acc, sq);
            sq = mul_mod(sq, sq);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Factorials upward, inverses from Fermat's rule at the top, then downward
    function automatic void build_tables();
        fact_mod[0] = 1;
        for (int i = 1; i <= TABLE_TOP; i++)
            fact_mod[i] = mul_mod(fact_mod[i-1], longint'(i));
        inv_fact_mod[TABLE_TOP] = pow_mod(fact_mod[TABLE_TOP], PRIME - 2);
        for (int i = TABLE_TOP; i > 0; i--)
            inv_fact_mod[i-1] = mul_mod(inv_fact_mod[i], longint'(i));
    endfunction

    function automatic t_binom_result predict_binomial(int n, int k);
        t_binom_result r;
        if (n > TABLE_TOP || k > n) begin
            r.coefficient  = '0;
            r.out_of_range = 1'b1;
        end else begin
            r.coefficient  = COEF_W'(mul_mod(mul_mod(fact_mod[n], inv_fact_mod[n-k]),
                                             inv_fact_mod[k]));
            r.out_of_range = 1'b0;
        end
        return r;
    endfunction

    // One query transfer; tvalid stays high for a following back-to-back query
    task automatic send_query(int n, int k);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {COUNT_W'(k), COUNT_W'(n)};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_binomial(n, k));
    endtask

    task automatic sender_quiet();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: long hold-offs on request, random stall bursts while idling
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_binom_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: tdata=%h tuser=%b", o_m_tdata, o_m_tuser);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tdata !== OUT_TDATA_W'(exp_r.coefficient)
                        || o_m_tuser[0] !== exp_r.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: coefficient exp %0d got %0d, ",
                                  "out_of_range exp %b got %b"},
                                 exp_r.coefficient, o_m_tdata, exp_r.out_of_range,
                                 o_m_tuser[0]);
                end
            end
        end
    end

    // Edges of both fields and every special case
    task automatic test_directed();
        idle_on = 1'b0;
        send_query(0, 0);
        send_query(1, 0);
        send_query(1, 1);
        send_query(5, 2);
        send_query(TABLE_TOP, 0);
        send_query(TABLE_TOP, TABLE_TOP);
        send_query(TABLE_TOP, TABLE_TOP / 2);
        send_query(TABLE_TOP, 1);
        send_query(TABLE_TOP - 1, TABLE_TOP - 2);
        // k greater than n
        send_query(5, 6);
        send_query(0, int'(COUNT_MAX));
        send_query(TABLE_TOP, TABLE_TOP + 1);
        send_query(TABLE_TOP - 1, TABLE_TOP);
        // n beyond the table; the last query has k greater than n
        send_query(TABLE_TOP + 1, 0);
        send_query(int'(COUNT_MAX), 0);
        send_query(int'(COUNT_MAX), int'(COUNT_MAX));
        send_query(12'hAAA, 12'h555);
        send_query(12'h555, 12'hAAA);
        sender_quiet();
    endtask

    // Random query mix: mostly answerable, some k > n, some full-range noise
    task automatic send_random_query();
        int n;
        int k;
        int pick = $urandom_range(0, 99);
        if (pick < 75) begin
            n = $urandom_range(0, TABLE_TOP);
            case ($urandom_range(0, 7))
                0:       k = 0;
                1:       k = n;
                default: k = $urandom_range(0, n);
            endcase
        end else if (pick < 88) begin
            n = $urandom_range(0, TABLE_TOP - 1);
            k = $urandom_range(n + 1, int'(COUNT_MAX));
        end else begin
            n = $urandom_range(0, int'(COUNT_MAX));
            k = $urandom_range(0, int'(COUNT_MAX));
        end
        send_query(n, k);
    endtask

    // Receiver holds off long enough for the result queue to fill and stall input
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 300;
        @(posedge i_clk);
        repeat (60) send_random_query();
        sender_quiet();
        wait_drained();
    endtask

    // Sender pauses for a full drain between short bursts
    task automatic test_drain_pause();
        idle_on = 1'b1;
        repeat (4) begin
            repeat (20) send_random_query();
            sender_quiet();
            wait_drained();
        end
    endtask

    // Phases with and without idling on both sides
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            idle_on = (phase % 3 != 2);
            repeat (200) send_random_query();
        end
        sender_quiet();
    endtask

    // Closing stretch at full rate
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (80) send_random_query();
        sender_quiet();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        build_tables();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random();
        test_full_rate();

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
